>>> src/mrpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types, constants and microcode program of the 32-bit
// Miller-Rabin primality tester.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int WORD_W = 32;
  localparam int SH_W   = 5;
  localparam int CNT_W  = 5;
  localparam int BASE_W = 6;
  localparam int BIDX_W = 2;
  localparam int STEP_W = 5;
  localparam int NUM_BASES = 3;
  localparam logic [BIDX_W-1:0] LAST_BIDX = BIDX_W'(NUM_BASES - 1);

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    ASEL_ACC  = 2'd0,
    ASEL_B    = 2'd1,
    ASEL_BASE = 2'd2
  } asel_t;

  typedef enum logic [1:0] {
    BSEL_B   = 2'd0,
    BSEL_ACC = 2'd1,
    BSEL_ONE = 2'd2
  } bsel_t;

  typedef enum logic {
    DST_ACC = 1'b0,
    DST_B   = 1'b1
  } dst_t;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_INIT   = 4'd1,
    OP_DSHIFT = 4'd2,
    OP_ESHIFT = 4'd3,
    OP_RINC   = 4'd4,
    OP_BINC   = 4'd5,
    OP_SETP   = 4'd6,
    OP_SETC   = 4'd7,
    OP_EMIT   = 4'd8
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER   = 4'd0,
    C_ALWAYS  = 4'd1,
    C_NOSTART = 4'd2,
    C_SMALLP  = 4'd3,
    C_SMALLC  = 4'd4,
    C_DODD    = 4'd5,
    C_MBUSY   = 4'd6,
    C_BZERO   = 4'd7,
    C_EZERO   = 4'd8,
    C_EEVEN   = 4'd9,
    C_XPASS   = 4'd10,
    C_RDONE   = 4'd11,
    C_XM1     = 4'd12,
    C_LASTB   = 4'd13,
    C_OUTBUSY = 4'd14
  } cond_t;

  typedef struct packed {
    logic  mul_start;
    asel_t a_sel;
    bsel_t b_sel;
    dst_t  dst;
    op_t   op;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic smallp;
    logic smallc;
    logic dodd;
    logic mbusy;
    logic bzero;
    logic ezero;
    logic eeven;
    logic xpass;
    logic rdone;
    logic xm1;
    logic lastb;
    logic outbusy;
  } flags_t;

  localparam step_t ST_WAIT   = 5'd0;
  localparam step_t ST_SMALLP = 5'd1;
  localparam step_t ST_SMALLC = 5'd2;
  localparam step_t ST_DTEST  = 5'd3;
  localparam step_t ST_DSHIFT = 5'd4;
  localparam step_t ST_BASE   = 5'd5;
  localparam step_t ST_BWAIT  = 5'd6;
  localparam step_t ST_BZERO  = 5'd7;
  localparam step_t ST_ELOOP  = 5'd8;
  localparam step_t ST_EBIT   = 5'd9;
  localparam step_t ST_EMUL   = 5'd10;
  localparam step_t ST_EMWAIT = 5'd11;
  localparam step_t ST_ESQR   = 5'd12;
  localparam step_t ST_ESWAIT = 5'd13;
  localparam step_t ST_EBACK  = 5'd14;
  localparam step_t ST_CHECK  = 5'd15;
  localparam step_t ST_SLOOP  = 5'd16;
  localparam step_t ST_SSQR   = 5'd17;
  localparam step_t ST_SWAIT  = 5'd18;
  localparam step_t ST_SCHECK = 5'd19;
  localparam step_t ST_SBACK  = 5'd20;
  localparam step_t ST_NEXTB  = 5'd21;
  localparam step_t ST_BBACK  = 5'd22;
  localparam step_t ST_PRIME  = 5'd23;
  localparam step_t ST_COMP   = 5'd24;
  localparam step_t ST_EMIT   = 5'd25;
  localparam step_t ST_RET    = 5'd26;

  function automatic logic [BASE_W-1:0] witness(input logic [BIDX_W-1:0] idx);
    logic [BASE_W-1:0] w;
    case (idx)
      2'd0:    w = 6'd2;
      2'd1:    w = 6'd7;
      2'd2:    w = 6'd61;
      default: w = 6'd2;
    endcase
    return w;
  endfunction

  function automatic ctl_t ctl_word(input logic ms, input asel_t a, input bsel_t b,
                                    input dst_t d, input op_t o, input cond_t c,
                                    input step_t t);
    ctl_t w;
    w.mul_start = ms;
    w.a_sel     = a;
    w.b_sel     = b;
    w.dst       = d;
    w.op        = o;
    w.cond      = c;
    w.target    = t;
    return w;
  endfunction

  function automatic ctl_t microcode(input step_t pc);
    ctl_t w;
    case (pc)
      ST_WAIT:   w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_NOSTART, ST_WAIT);
      ST_SMALLP: w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_SMALLP, ST_PRIME);
      ST_SMALLC: w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_SMALLC, ST_COMP);
      ST_DTEST:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_DODD, ST_BASE);
      ST_DSHIFT: w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_DSHIFT, C_ALWAYS, ST_DTEST);
      ST_BASE:   w = ctl_word(1'b1, ASEL_BASE, BSEL_ONE, DST_B, OP_INIT, C_NEVER, ST_WAIT);
      ST_BWAIT:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_MBUSY, ST_BWAIT);
      ST_BZERO:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_BZERO, ST_NEXTB);
      ST_ELOOP:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_EZERO, ST_CHECK);
      ST_EBIT:   w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_EEVEN, ST_ESQR);
      ST_EMUL:   w = ctl_word(1'b1, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_NEVER, ST_WAIT);
      ST_EMWAIT: w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_MBUSY, ST_EMWAIT);
      ST_ESQR:   w = ctl_word(1'b1, ASEL_B, BSEL_B, DST_B, OP_ESHIFT, C_NEVER, ST_WAIT);
      ST_ESWAIT: w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_MBUSY, ST_ESWAIT);
      ST_EBACK:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_ALWAYS, ST_ELOOP);
      ST_CHECK:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_XPASS, ST_NEXTB);
      ST_SLOOP:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_RDONE, ST_COMP);
      ST_SSQR:   w = ctl_word(1'b1, ASEL_ACC, BSEL_ACC, DST_ACC, OP_RINC, C_NEVER, ST_WAIT);
      ST_SWAIT:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_MBUSY, ST_SWAIT);
      ST_SCHECK: w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_XM1, ST_NEXTB);
      ST_SBACK:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_ALWAYS, ST_SLOOP);
      ST_NEXTB:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_BINC, C_LASTB, ST_PRIME);
      ST_BBACK:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_ALWAYS, ST_BASE);
      ST_PRIME:  w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_SETP, C_ALWAYS, ST_EMIT);
      ST_COMP:   w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_SETC, C_NEVER, ST_WAIT);
      ST_EMIT:   w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_EMIT, C_OUTBUSY, ST_EMIT);
      ST_RET:    w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_ALWAYS, ST_WAIT);
      default:   w = ctl_word(1'b0, ASEL_ACC, BSEL_B, DST_ACC, OP_NONE, C_ALWAYS, ST_WAIT);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> src/miller_rabin_prime_test_32_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_32_core
// Deterministic Miller-Rabin test of a 32-bit word with bases 2, 7 and 61.
//
// Channel   Dir  Word        Contents
// in_       in   32 bits     candidate
// out_      out  8 bits      is_prime in bit 0, rest zero
//
// One candidate at a time. Each modular multiply runs in the shift-subtract
// unit; a base costs up to about 2*bits(d)+s multiplies, while even or small
// values are settled without any multiply.
// Reset clears the step counter and the output valid flag.
// A new word is taken once the previous result is parked in the output
// register; the sequencer holds at its emit step while that register is full.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_32_core
  import mrpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] candidate
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [0] is_prime, [7:1] zero
);

  logic              in_fire;
  ctl_t              ctl;
  flags_t            flags;
  logic              idle;
  logic              mul_busy, mul_done;
  logic [WORD_W-1:0] mul_a, mul_b, mul_p;
  logic [WORD_W-1:0] nm1;

  logic [WORD_W-1:0] n_r, n_nxt;
  logic [WORD_W-1:0] d_r, d_nxt;
  logic [SH_W-1:0]   s_r, s_nxt;
  logic [WORD_W-1:0] e_r, e_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [SH_W-1:0]   r_r, r_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic              res_r, res_nxt;
  dst_t              dst_r, dst_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_prime_r, out_prime_nxt;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;
  assign nm1       = n_r - 1'b1;

  always_comb begin
    flags.start   = in_fire;
    flags.smallp  = (n_r == WORD_W'(2)) || (n_r == WORD_W'(3));
    flags.smallc  = (n_r < WORD_W'(3)) || !n_r[0];
    flags.dodd    = d_r[0];
    flags.mbusy   = mul_busy;
    flags.bzero   = (b_r == '0);
    flags.ezero   = (e_r == '0);
    flags.eeven   = !e_r[0];
    flags.xpass   = (acc_r == WORD_W'(1)) || (acc_r == nm1);
    flags.rdone   = (r_r == s_r);
    flags.xm1     = (acc_r == nm1);
    flags.lastb   = (bidx_r == LAST_BIDX);
    flags.outbusy = out_valid_r && !out_tready;
  end

  mrpt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl),
    .idle  (idle)
  );

  always_comb begin
    case (ctl.a_sel)
      ASEL_ACC:  mul_a = acc_r;
      ASEL_B:    mul_a = b_r;
      ASEL_BASE: mul_a = {{(WORD_W-BASE_W){1'b0}}, witness(bidx_r)};
      default:   mul_a = acc_r;
    endcase
    case (ctl.b_sel)
      BSEL_B:   mul_b = b_r;
      BSEL_ACC: mul_b = acc_r;
      BSEL_ONE: mul_b = WORD_W'(1);
      default:  mul_b = b_r;
    endcase
  end

  mrpt_modmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (n_r),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    n_nxt         = n_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    bidx_nxt      = bidx_r;
    res_nxt       = res_r;
    dst_nxt       = dst_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_prime_nxt = out_prime_r;

    if (in_fire) begin
      n_nxt    = in_tdata;
      d_nxt    = in_tdata - 1'b1;
      s_nxt    = '0;
      bidx_nxt = '0;
    end
    if (ctl.mul_start) begin
      dst_nxt = ctl.dst;
    end
    if (mul_done) begin
      if (dst_r == DST_B) begin
        b_nxt = mul_p;
      end else begin
        acc_nxt = mul_p;
      end
    end

    case (ctl.op)
      OP_NONE: begin
      end
      OP_INIT: begin
        acc_nxt = WORD_W'(1);
        e_nxt   = d_r;
        r_nxt   = SH_W'(1);
      end
      OP_DSHIFT: begin
        d_nxt = d_r >> 1;
        s_nxt = s_r + 1'b1;
      end
      OP_ESHIFT: begin
        e_nxt = e_r >> 1;
      end
      OP_RINC: begin
        r_nxt = r_r + 1'b1;
      end
      OP_BINC: begin
        bidx_nxt = bidx_r + 1'b1;
      end
      OP_SETP: begin
        res_nxt = 1'b1;
      end
      OP_SETC: begin
        res_nxt = 1'b0;
      end
      OP_EMIT: begin
        if (!flags.outbusy) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    d_r         <= d_nxt;
    s_r         <= s_nxt;
    e_r         <= e_nxt;
    acc_r       <= acc_nxt;
    b_r         <= b_nxt;
    r_r         <= r_nxt;
    bidx_r      <= bidx_nxt;
    res_r       <= res_nxt;
    dst_r       <= dst_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_prime_r};

endmodule
`default_nettype wire

>>> src/mrpt_modmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrpt_modmul
// Interleaved shift-subtract modular multiplier: p = a * b mod m, one bit of
// a per cycle from the top, b below m. Result valid when done pulses.
// ----------------------------------------------------------------------------
module mrpt_modmul
  import mrpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  input  wire logic [WORD_W-1:0] m,
  output logic                   busy,
  output logic                   done,
  output logic      [WORD_W-1:0] p
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W-1:0] m_r, m_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W:0]   dbl, dbl_red, sum, sum_red, m_ext;

  always_comb begin
    m_ext   = {1'b0, m_r};
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + (a_r[WORD_W-1] ? {1'b0, b_r} : '0);
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      a_nxt    = a;
      b_nxt    = b;
      m_nxt    = m;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = sum_red[WORD_W-1:0];
      a_nxt   = {a_r[WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

>>> src/mrpt_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrpt_seq
// Microcode sequencer: step counter, program table and conditional jumps.
// ----------------------------------------------------------------------------
module mrpt_seq
  import mrpt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire flags_t flags,
  output ctl_t        ctl,
  output logic        idle
);

  step_t pc_r, pc_nxt;
  logic  take;

  assign ctl  = microcode(pc_r);
  assign idle = (pc_r == ST_WAIT);

  always_comb begin
    case (ctl.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NOSTART: take = !flags.start;
      C_SMALLP:  take = flags.smallp;
      C_SMALLC:  take = flags.smallc;
      C_DODD:    take = flags.dodd;
      C_MBUSY:   take = flags.mbusy;
      C_BZERO:   take = flags.bzero;
      C_EZERO:   take = flags.ezero;
      C_EEVEN:   take = flags.eeven;
      C_XPASS:   take = flags.xpass;
      C_RDONE:   take = flags.rdone;
      C_XM1:     take = flags.xm1;
      C_LASTB:   take = flags.lastb;
      C_OUTBUSY: take = flags.outbusy;
      default:   take = 1'b0;
    endcase
    pc_nxt = take ? ctl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire
